@@ design/merge_sort_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Merge sort engine assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define MSE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MSE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MSE_ASSERT(name, clk, rst_n, prop)
`define MSE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ design/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine package
// Default sizes and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic sort_start;
    logic run_start;
    logic read;
    logic merge;
    logic run_next;
    logic pass_next;
    logic out_start;
    logic out_read;
    logic out_load;
    logic clear;
  } mse_cmd_t;

  typedef struct packed {
    logic run_done;
    logic pass_done;
    logic sort_done;
    logic out_done;
  } mse_sts_t;

endpackage

@@ design/mse_datapath.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine datapath
// Two ping-pong element memories, merge pointers, comparator and output
// registers.
// ----------------------------------------------------------------------------
`include "merge_sort_engine_macros.svh"

module mse_datapath
  import mse_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mse_cmd_t                     cmd_i,
  output mse_sts_t                     sts_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic signed [DATA_WIDTH-1:0] sorted_value_o,
  output logic                         end_of_set_o,
  output logic                         overflow_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + 1;

  logic signed [DATA_WIDTH-1:0] mem0 [CAPACITY];
  logic signed [DATA_WIDTH-1:0] mem1 [CAPACITY];

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          src_q, src_d;
  logic [PW-1:0] width_q, width_d;
  logic [PW-1:0] lo_q, lo_d;
  logic [PW-1:0] mid_q, mid_d;
  logic [PW-1:0] hi_q, hi_d;
  logic [PW-1:0] i_q, i_d;
  logic [PW-1:0] j_q, j_d;
  logic [PW-1:0] k_q, k_d;

  logic signed [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
  logic signed [DATA_WIDTH-1:0] sorted_q;
  logic                         end_q;
  logic                         ovf_out_q;

  logic [PW-1:0]                cnt_ext;
  logic [PW-1:0]                lo_w, lo_2w, mid_n, hi_n;
  logic                         take_a;
  logic                         not_full;
  logic                         we0, we1;
  logic [IW-1:0]                waddr, ra, rb;
  logic signed [DATA_WIDTH-1:0] wdata;

  assign cnt_ext  = PW'(count_q);
  assign not_full = count_q < CW'(CAPACITY);
  assign lo_w     = lo_q + width_q;
  assign lo_2w    = lo_q + (width_q << 1);
  assign mid_n    = (lo_w < cnt_ext) ? lo_w : cnt_ext;
  assign hi_n     = (lo_2w < cnt_ext) ? lo_2w : cnt_ext;
  assign take_a   = (i_q < mid_q) && ((j_q >= hi_q) || (rd_a_q <= rd_b_q));

  assign we0   = (cmd_i.load && not_full) || (cmd_i.merge && src_q);
  assign we1   = cmd_i.merge && !src_q;
  assign waddr = cmd_i.load ? count_q[IW-1:0] : k_q[IW-1:0];
  assign wdata = cmd_i.load ? value_i : (take_a ? rd_a_q : rd_b_q);
  assign ra    = cmd_i.out_read ? k_q[IW-1:0] : i_q[IW-1:0];
  assign rb    = j_q[IW-1:0];

  assign sts_o.run_done  = (i_q >= mid_q) && (j_q >= hi_q);
  assign sts_o.pass_done = lo_q >= cnt_ext;
  assign sts_o.sort_done = width_q >= cnt_ext;
  assign sts_o.out_done  = k_q >= cnt_ext;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    src_d   = src_q;
    width_d = width_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    if (cmd_i.load) begin
      if (not_full) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.sort_start) begin
      width_d = PW'(1);
      lo_d    = '0;
    end
    if (cmd_i.run_start) begin
      mid_d = mid_n;
      hi_d  = hi_n;
      i_d   = lo_q;
      j_d   = mid_n;
      k_d   = lo_q;
    end
    if (cmd_i.merge) begin
      k_d = k_q + PW'(1);
      if (take_a) begin
        i_d = i_q + PW'(1);
      end else begin
        j_d = j_q + PW'(1);
      end
    end
    if (cmd_i.run_next) begin
      lo_d = lo_2w;
    end
    if (cmd_i.pass_next) begin
      width_d = width_q << 1;
      lo_d    = '0;
      src_d   = ~src_q;
    end
    if (cmd_i.out_start) begin
      k_d = '0;
    end
    if (cmd_i.out_load) begin
      k_d = k_q + PW'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
      src_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      src_q   <= 1'b0;
      width_q <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      src_q   <= src_d;
      width_q <= width_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    if (we1) begin
      mem1[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read || cmd_i.out_read) begin
      rd_a_q <= src_q ? mem1[ra] : mem0[ra];
      rd_b_q <= src_q ? mem1[rb] : mem0[rb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sorted_q  <= rd_a_q;
      end_q     <= (k_q + PW'(1)) == cnt_ext;
      ovf_out_q <= ovf_q;
    end
  end

  assign sorted_value_o = sorted_q;
  assign end_of_set_o   = end_q;
  assign overflow_o     = ovf_out_q;

  `MSE_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CW'(CAPACITY))
  `MSE_ASSERT(a_merge_in_run, clk_i, rst_ni, cmd_i.merge |-> (k_q < hi_q) && (hi_q <= cnt_ext))

endmodule

@@ design/mse_ctrl.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine controller
// Sequences loading, the bottom-up merge passes and the output drain.
// ----------------------------------------------------------------------------
`include "merge_sort_engine_macros.svh"

module mse_ctrl
  import mse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     is_last_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mse_cmd_t cmd_o,
  input  mse_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_RUN,
    S_RD,
    S_MRG,
    S_ORD,
    S_OLD,
    S_OSH
  } state_e;

  state_e   state_q, state_d;
  logic     in_ready_q, in_ready_d;
  logic     out_valid_q, out_valid_d;
  mse_cmd_t cmd;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_ready_q) begin
          cmd.load = 1'b1;
          if (is_last_i) begin
            cmd.sort_start = 1'b1;
            in_ready_d     = 1'b0;
            state_d        = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (sts_i.sort_done) begin
          cmd.out_start = 1'b1;
          state_d       = S_ORD;
        end else begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (sts_i.pass_done) begin
          cmd.pass_next = 1'b1;
          state_d       = S_PASS;
        end else begin
          cmd.run_start = 1'b1;
          state_d       = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.run_done) begin
          cmd.run_next = 1'b1;
          state_d      = S_RUN;
        end else begin
          cmd.read = 1'b1;
          state_d  = S_MRG;
        end
      end
      S_MRG: begin
        cmd.merge = 1'b1;
        state_d   = S_RD;
      end
      S_ORD: begin
        cmd.out_read = 1'b1;
        state_d      = S_OLD;
      end
      S_OLD: begin
        cmd.out_load = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_OSH;
      end
      S_OSH: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (sts_i.out_done) begin
            cmd.clear  = 1'b1;
            in_ready_d = 1'b1;
            state_d    = S_LOAD;
          end else begin
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  `MSE_ASSERT_ALWAYS(a_no_overlap, clk_i, !(in_ready_o && out_valid_o))
  `MSE_ASSERT(a_end_reloads, clk_i, rst_ni, (out_valid_o && out_ready_i && sts_i.out_done) |=> in_ready_o)

endmodule

@@ design/merge_sort_engine.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine
// Collects a set of signed values and returns it in ascending order.
// ----------------------------------------------------------------------------
// Values are loaded one per cycle until a transaction with is_last_i set; up
// to CAPACITY values are kept and later ones are dropped, which sets overflow_o
// on every result of that set. The set of N values is then sorted by
// bottom-up merge passes between two on-chip memories: ceil(log2 N) passes,
// in which every merge step first reads both run heads from a memory with
// registered read data and then writes the smaller one. Results are then
// drained one element at a time: each is read, loaded into the output
// register and held until out_ready_i takes it, the last one flagged by
// end_of_set_o. No new set is accepted until the final result transaction
// of the current set.
// ----------------------------------------------------------------------------
module merge_sort_engine
  import mse_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         is_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] sorted_value_o,
  output logic                         end_of_set_o,
  output logic                         overflow_o
);

  mse_cmd_t cmd;
  mse_sts_t sts;

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mse_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .sorted_value_o (sorted_value_o),
    .end_of_set_o   (end_of_set_o),
    .overflow_o     (overflow_o)
  );

endmodule
